[design/sit_pkg.sv]
// Shared constants and types for the segment intersection test.
package sit_pkg;

	localparam int COORD_WIDTH_DEF = 16;

	typedef enum logic [1:0] {
		KIND_PARALLEL  = 2'd0,
		KIND_COLLINEAR = 2'd1,
		KIND_CROSSING  = 2'd2
	} case_kind_t;

endpackage

[design/sit_mul_stage.sv]
// Product stage: every partial product of the cross and dot products, registered.
module sit_mul_stage #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          v_in,
	input  logic signed [COORD_WIDTH-1:0] r_x,
	input  logic signed [COORD_WIDTH-1:0] r_y,
	input  logic signed [COORD_WIDTH-1:0] s_x,
	input  logic signed [COORD_WIDTH-1:0] s_y,
	input  logic signed [COORD_WIDTH:0]   w_x,
	input  logic signed [COORD_WIDTH:0]   w_y,
	output logic                          v_s2,
	output logic signed [2*COORD_WIDTH-1:0] rs_a_s2,
	output logic signed [2*COORD_WIDTH-1:0] rs_b_s2,
	output logic signed [2*COORD_WIDTH:0]   ws_a_s2,
	output logic signed [2*COORD_WIDTH:0]   ws_b_s2,
	output logic signed [2*COORD_WIDTH:0]   wr_a_s2,
	output logic signed [2*COORD_WIDTH:0]   wr_b_s2,
	output logic signed [2*COORD_WIDTH-1:0] rr_a_s2,
	output logic signed [2*COORD_WIDTH-1:0] rr_b_s2,
	output logic signed [2*COORD_WIDTH:0]   wd_a_s2,
	output logic signed [2*COORD_WIDTH:0]   wd_b_s2,
	output logic signed [2*COORD_WIDTH-1:0] sr_a_s2,
	output logic signed [2*COORD_WIDTH-1:0] sr_b_s2
);
	localparam int PN = 2 * COORD_WIDTH;
	localparam int PW = 2 * COORD_WIDTH + 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		// r x s
		rs_a_s2 <= PN'(r_x) * PN'(s_y);
		rs_b_s2 <= PN'(r_y) * PN'(s_x);
		// w x s
		ws_a_s2 <= PW'(w_x) * PW'(s_y);
		ws_b_s2 <= PW'(w_y) * PW'(s_x);
		// w x r
		wr_a_s2 <= PW'(w_x) * PW'(r_y);
		wr_b_s2 <= PW'(w_y) * PW'(r_x);
		// r . r
		rr_a_s2 <= PN'(r_x) * PN'(r_x);
		rr_b_s2 <= PN'(r_y) * PN'(r_y);
		// w . r
		wd_a_s2 <= PW'(w_x) * PW'(r_x);
		wd_b_s2 <= PW'(w_y) * PW'(r_y);
		// s . r
		sr_a_s2 <= PN'(s_x) * PN'(r_x);
		sr_b_s2 <= PN'(s_y) * PN'(r_y);
	end

endmodule

[design/sit_sum_stage.sv]
// Sum stage: combine product pairs into the cross and dot products.
module sit_sum_stage #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            v_in,
	input  logic signed [2*COORD_WIDTH-1:0] rs_a,
	input  logic signed [2*COORD_WIDTH-1:0] rs_b,
	input  logic signed [2*COORD_WIDTH:0]   ws_a,
	input  logic signed [2*COORD_WIDTH:0]   ws_b,
	input  logic signed [2*COORD_WIDTH:0]   wr_a,
	input  logic signed [2*COORD_WIDTH:0]   wr_b,
	input  logic signed [2*COORD_WIDTH-1:0] rr_a,
	input  logic signed [2*COORD_WIDTH-1:0] rr_b,
	input  logic signed [2*COORD_WIDTH:0]   wd_a,
	input  logic signed [2*COORD_WIDTH:0]   wd_b,
	input  logic signed [2*COORD_WIDTH-1:0] sr_a,
	input  logic signed [2*COORD_WIDTH-1:0] sr_b,
	output logic                            v_s3,
	output logic signed [2*COORD_WIDTH+2:0] d_s3,
	output logic signed [2*COORD_WIDTH+2:0] x_s3,
	output logic signed [2*COORD_WIDTH+2:0] y_s3,
	output logic signed [2*COORD_WIDTH+2:0] rr_s3,
	output logic signed [2*COORD_WIDTH+2:0] a_s3,
	output logic signed [2*COORD_WIDTH+2:0] b_s3
);
	localparam int SW = 2 * COORD_WIDTH + 3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		d_s3  <= SW'(rs_a) - SW'(rs_b);
		x_s3  <= SW'(ws_a) - SW'(ws_b);
		y_s3  <= SW'(wr_a) - SW'(wr_b);
		rr_s3 <= SW'(rr_a) + SW'(rr_b);
		a_s3  <= SW'(wd_a) + SW'(wd_b);
		b_s3  <= SW'(sr_a) + SW'(sr_b);
	end

endmodule

[design/sit_decide_stage.sv]
// Decision stage: classify the pair and test the parameters against [0,1].
module sit_decide_stage #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            v_in,
	input  logic signed [2*COORD_WIDTH+2:0] d,
	input  logic signed [2*COORD_WIDTH+2:0] x,
	input  logic signed [2*COORD_WIDTH+2:0] y,
	input  logic signed [2*COORD_WIDTH+2:0] rr,
	input  logic signed [2*COORD_WIDTH+2:0] a,
	input  logic signed [2*COORD_WIDTH+2:0] b,
	output logic                            v_s4,
	output logic                            hit_s4,
	output sit_pkg::case_kind_t             kind_s4
);
	import sit_pkg::*;

	localparam int SW = 2 * COORD_WIDTH + 3;

	logic signed [SW-1:0] e;
	logic                 d_zero;
	logic                 y_zero;
	logic                 above;
	logic                 below;
	logic                 t_in;
	logic                 u_in;
	logic                 hit_d;
	case_kind_t           kind_d;

	always_comb begin
		e      = a + b;
		d_zero = (d == '0);
		y_zero = (y == '0);
		above  = (rr < a) && (rr < e);
		below  = (a < 0) && (e < 0);
		// sign of the denominator picks which bound is zero
		if (d < 0) begin
			t_in = (x >= d) && (x <= 0);
			u_in = (y >= d) && (y <= 0);
		end else begin
			t_in = (x >= 0) && (x <= d);
			u_in = (y >= 0) && (y <= d);
		end
		if (d_zero && !y_zero) begin
			kind_d = KIND_PARALLEL;
			hit_d  = 1'b0;
		end else if (d_zero) begin
			// a zero-length r leaves a, e and rr all zero: neither bound trips
			kind_d = KIND_COLLINEAR;
			hit_d  = !(above || below);
		end else begin
			kind_d = KIND_CROSSING;
			hit_d  = t_in && u_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		hit_s4  <= hit_d;
		kind_s4 <= kind_d;
	end

	a_parallel_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && kind_s4 == KIND_PARALLEL) |-> !hit_s4)
		else $error("parallel disjoint pair reported as hit");

	a_zero_r_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(v_in && d_zero && y_zero && rr == '0) |=> (hit_s4 && kind_s4 == KIND_COLLINEAR))
		else $error("zero-length segment A not reported as collinear hit");

	a_crossing_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(v_in && !d_zero) |=> (kind_s4 == KIND_CROSSING))
		else $error("non-parallel pair misclassified");

endmodule

[design/segment_intersection_test.sv]
// Top level of the two-segment intersection test pipeline.
//
// Usage: drive the eight coordinate ports and raise start for one cycle per
// word; a word is taken at every rising edge where start is high and busy is
// low. busy is never raised, so a new pair of segments may enter every cycle.
// Each word yields one result: done is high for exactly one cycle while hit
// and case_kind carry the answer for that word once it has passed through the
// difference, product, sum and decision stages; throughput is one word per
// cycle, and the stage holding twelve multipliers sets the cycle time.
// case_kind: parallel disjoint, collinear, or crossing (non-parallel).
// Reset clears all stage valid bits; words in flight are dropped and no done
// follows them. The receiver cannot hold results off, so nothing stalls and
// every result is shown once, in order of entry.
module segment_intersection_test #(
	parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] a_start_x,
	input  logic signed [COORD_WIDTH-1:0] a_start_y,
	input  logic signed [COORD_WIDTH-1:0] a_disp_x,
	input  logic signed [COORD_WIDTH-1:0] a_disp_y,
	input  logic signed [COORD_WIDTH-1:0] b_start_x,
	input  logic signed [COORD_WIDTH-1:0] b_start_y,
	input  logic signed [COORD_WIDTH-1:0] b_disp_x,
	input  logic signed [COORD_WIDTH-1:0] b_disp_y,
	output logic                          done,
	output logic                          hit,
	output sit_pkg::case_kind_t           case_kind
);
	import sit_pkg::*;

	localparam int W = COORD_WIDTH;

	logic                 v_s1;
	logic signed [W-1:0]  r_x_s1;
	logic signed [W-1:0]  r_y_s1;
	logic signed [W-1:0]  s_x_s1;
	logic signed [W-1:0]  s_y_s1;
	logic signed [W:0]    w_x_s1;
	logic signed [W:0]    w_y_s1;

	logic                 v_s2;
	logic signed [2*W-1:0] rs_a_s2, rs_b_s2, rr_a_s2, rr_b_s2, sr_a_s2, sr_b_s2;
	logic signed [2*W:0]   ws_a_s2, ws_b_s2, wr_a_s2, wr_b_s2, wd_a_s2, wd_b_s2;

	logic                 v_s3;
	logic signed [2*W+2:0] d_s3, x_s3, y_s3, rr_s3, a_s3, b_s3;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	// w = q - p, one bit wider than a coordinate
	always_ff @(posedge clk) begin
		r_x_s1 <= a_disp_x;
		r_y_s1 <= a_disp_y;
		s_x_s1 <= b_disp_x;
		s_y_s1 <= b_disp_y;
		w_x_s1 <= {b_start_x[W-1], b_start_x} - {a_start_x[W-1], a_start_x};
		w_y_s1 <= {b_start_y[W-1], b_start_y} - {a_start_y[W-1], a_start_y};
	end

	sit_mul_stage #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.v_in   (v_s1),
		.r_x    (r_x_s1),
		.r_y    (r_y_s1),
		.s_x    (s_x_s1),
		.s_y    (s_y_s1),
		.w_x    (w_x_s1),
		.w_y    (w_y_s1),
		.v_s2   (v_s2),
		.rs_a_s2(rs_a_s2),
		.rs_b_s2(rs_b_s2),
		.ws_a_s2(ws_a_s2),
		.ws_b_s2(ws_b_s2),
		.wr_a_s2(wr_a_s2),
		.wr_b_s2(wr_b_s2),
		.rr_a_s2(rr_a_s2),
		.rr_b_s2(rr_b_s2),
		.wd_a_s2(wd_a_s2),
		.wd_b_s2(wd_b_s2),
		.sr_a_s2(sr_a_s2),
		.sr_b_s2(sr_b_s2)
	);

	sit_sum_stage #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_sum (
		.clk   (clk),
		.arst_n(arst_n),
		.v_in  (v_s2),
		.rs_a  (rs_a_s2),
		.rs_b  (rs_b_s2),
		.ws_a  (ws_a_s2),
		.ws_b  (ws_b_s2),
		.wr_a  (wr_a_s2),
		.wr_b  (wr_b_s2),
		.rr_a  (rr_a_s2),
		.rr_b  (rr_b_s2),
		.wd_a  (wd_a_s2),
		.wd_b  (wd_b_s2),
		.sr_a  (sr_a_s2),
		.sr_b  (sr_b_s2),
		.v_s3  (v_s3),
		.d_s3  (d_s3),
		.x_s3  (x_s3),
		.y_s3  (y_s3),
		.rr_s3 (rr_s3),
		.a_s3  (a_s3),
		.b_s3  (b_s3)
	);

	sit_decide_stage #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_decide (
		.clk    (clk),
		.arst_n (arst_n),
		.v_in   (v_s3),
		.d      (d_s3),
		.x      (x_s3),
		.y      (y_s3),
		.rr     (rr_s3),
		.a      (a_s3),
		.b      (b_s3),
		.v_s4   (done),
		.hit_s4 (hit),
		.kind_s4(case_kind)
	);

	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 4))
		else $error("result strobe without a word taken four cycles earlier");

endmodule
